// ===== hw/rtl/mbps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int OFFSET_BITS = 32;
    localparam int LEN_BITS    = $clog2(PATTERN_MAX + 1);
    localparam int MATCH_BITS  = 32;

    localparam logic [OFFSET_BITS-1:0] OFFSET_TOP = '1;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_DATA   = 2'd2,
        CMD_RSVD   = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        ST_MATCH   = 2'd0,
        ST_NONE    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef struct packed {
        logic shift_win;
        logic shift_pat;
        logic clear_pat;
    } mbps_ctrl_t;

    typedef struct packed {
        status_t               status;
        logic [MATCH_BITS-1:0] match_offset;
    } mbps_result_t;

endpackage

// ===== hw/rtl/mbps_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_cell
// One window position: a window byte, the pattern element compared with it,
// and an active bit; hands all of them on to the next cell.
// ----------------------------------------------------------------------------
module mbps_cell
    import mbps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  mbps_ctrl_t ctrl,
    input  logic [7:0] win_in,
    input  logic [7:0] pbyte_in,
    input  logic       care_in,
    input  logic       active_in,
    output logic [7:0] win_out,
    output logic [7:0] pbyte_out,
    output logic       care_out,
    output logic       active_out,
    output logic       hit
);

    logic [7:0] win_reg, win_next;
    logic [7:0] pbyte_reg, pbyte_next;
    logic       care_reg, care_next;
    logic       active_reg, active_next;

    always_comb
    begin
        win_next    = ctrl.shift_win ? win_in : win_reg;
        pbyte_next  = ctrl.shift_pat ? pbyte_in : pbyte_reg;
        care_next   = ctrl.shift_pat ? care_in : care_reg;
        active_next = active_reg;
        if (ctrl.clear_pat)
        begin
            active_next = 1'b0;
        end
        else if (ctrl.shift_pat)
        begin
            active_next = active_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg   <= win_next;
        pbyte_reg <= pbyte_next;
        care_reg  <= care_next;
    end

    // compare against the window as it stands once the incoming byte shifts in
    assign hit        = !active_reg || !care_reg || (win_in == pbyte_reg);
    assign win_out    = win_reg;
    assign pbyte_out  = pbyte_reg;
    assign care_out   = care_reg;
    assign active_out = active_reg;

endmodule

// ===== hw/rtl/mbps_out_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_out_skid
// Output register with a skid entry behind it, so a new item is taken while
// a result waits for the receiver.
// ----------------------------------------------------------------------------
module mbps_out_skid
    import mbps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  mbps_result_t in_res,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    output mbps_result_t out_res
);

    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    mbps_result_t out_res_reg, out_res_next;
    mbps_result_t skid_res_reg, skid_res_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = in_valid;
                skid_res_next   = in_res;
            end
            else
            begin
                out_valid_next = in_valid;
                out_res_next   = in_res;
            end
        end
        else if (in_valid)
        begin
            // hold the waiting result, park the new one
            skid_valid_next = 1'b1;
            skid_res_next   = in_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

// ===== hw/rtl/masked_byte_pattern_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// Finds the first match of a masked byte pattern within each byte region.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): s_tuser carries the command (clear pattern, append
//   pattern element, region byte). s_tdata holds the byte and the care bit;
//   s_tlast marks the last byte of a region.
//   Output channel (m_*): one item per region's first match (status match, offset of the
//   first matching byte) or, on a region's last byte without a match, a
//   no-match or invalid-pattern status with offset zero.
//   Throughput: one input item per cycle while s_tready is high. The window
//   compare runs across all PATTERN_MAX cells in parallel in the cycle of
//   acceptance; the result is registered before it appears on m_*.
//   Stall: results go to an output register with one skid entry behind it;
//   s_tready drops only while both hold results.
//   Reset: pattern empty, no overflow, region counters cleared; no clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner
    import mbps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] byte_value, [8] care, [15:9] zero
    input  logic [1:0]  s_tuser,   // [1:0] command
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] match_offset
    output logic [1:0]  m_tuser    // [1:0] status
);

    command_t   cmd;
    logic [7:0] byte_value;
    logic       care;
    logic       accept;
    mbps_ctrl_t ctrl;

    logic [LEN_BITS-1:0]    len_reg, len_next;
    logic                   ovf_reg, ovf_next;
    logic [OFFSET_BITS-1:0] seen_reg, seen_next;
    logic                   reported_reg, reported_next;

    logic [PATTERN_MAX-1:0] hits;
    logic [PATTERN_MAX-1:0] active;
    logic [7:0]             win_chain   [PATTERN_MAX+1];
    logic [7:0]             pbyte_chain [PATTERN_MAX+1];
    logic                   care_chain  [PATTERN_MAX+1];
    logic                   act_chain   [PATTERN_MAX+1];

    logic                   full;
    logic                   pat_valid;
    logic                   is_data;
    logic                   found;
    logic [OFFSET_BITS-1:0] offset;
    logic                   res_valid;
    mbps_result_t           res;
    mbps_result_t           out_res;

    assign cmd        = command_t'(s_tuser);
    assign byte_value = s_tdata[7:0];
    assign care       = s_tdata[8];
    assign accept     = s_tvalid && s_tready;
    assign full       = (len_reg == LEN_BITS'(PATTERN_MAX));
    assign is_data    = accept && (cmd == CMD_DATA);

    assign ctrl.shift_win = is_data;
    assign ctrl.shift_pat = accept && (cmd == CMD_APPEND) && !full;
    assign ctrl.clear_pat = accept && (cmd == CMD_CLEAR);

    // cell 0 takes the new byte; the newest pattern element lines up with it
    assign win_chain[0]   = byte_value;
    assign pbyte_chain[0] = byte_value;
    assign care_chain[0]  = care;
    assign act_chain[0]   = 1'b1;

    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        mbps_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .win_in     (win_chain[k]),
            .pbyte_in   (pbyte_chain[k]),
            .care_in    (care_chain[k]),
            .active_in  (act_chain[k]),
            .win_out    (win_chain[k+1]),
            .pbyte_out  (pbyte_chain[k+1]),
            .care_out   (care_chain[k+1]),
            .active_out (act_chain[k+1]),
            .hit        (hits[k])
        );
        assign active[k] = act_chain[k+1];
    end

    always_comb
    begin
        seen_next = seen_reg;
        if (seen_reg != OFFSET_TOP)
        begin
            seen_next = seen_reg + OFFSET_BITS'(1);
        end
        pat_valid = (len_reg != '0) && !ovf_reg;
        found     = is_data && pat_valid && !reported_reg &&
                    (seen_next >= OFFSET_BITS'(len_reg)) && (&hits);
        offset    = seen_reg - OFFSET_BITS'(len_reg - LEN_BITS'(1));

        res_valid        = 1'b0;
        res.status       = ST_MATCH;
        res.match_offset = MATCH_BITS'(offset);
        if (found)
        begin
            res_valid = 1'b1;
        end
        else if (is_data && s_tlast && !reported_reg)
        begin
            res_valid        = 1'b1;
            res.status       = pat_valid ? ST_NONE : ST_INVALID;
            res.match_offset = '0;
        end
    end

    always_comb
    begin
        len_next      = len_reg;
        ovf_next      = ovf_reg;
        reported_next = reported_reg;
        if (ctrl.clear_pat)
        begin
            len_next = '0;
            ovf_next = 1'b0;
        end
        else if (accept && (cmd == CMD_APPEND))
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                len_next = len_reg + LEN_BITS'(1);
            end
        end
        if (is_data)
        begin
            if (s_tlast)
            begin
                reported_next = 1'b0;
            end
            else if (found)
            begin
                reported_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            seen_reg     <= '0;
            reported_reg <= 1'b0;
        end
        else
        begin
            len_reg      <= len_next;
            ovf_reg      <= ovf_next;
            reported_reg <= reported_next;
            if (is_data)
            begin
                // drop the region count after its last byte
                seen_reg <= s_tlast ? '0 : seen_next;
            end
        end
    end

    mbps_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = out_res.match_offset;
    assign m_tuser = out_res.status;

    a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(active) == int'(len_reg))
        else $error("active cells disagree with pattern length");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> full)
        else $error("overflow flagged with pattern not full");

    a_region_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (is_data && s_tlast) |=> (seen_reg == '0) && !reported_reg)
        else $error("region state not cleared after last byte");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

endmodule
